// ===== rtl/positional_list_queue_defines.svh =====
// Assertion macros shared by the positional list queue checker.
// Stand-alone header, no dependencies.
`ifndef POSITIONAL_LIST_QUEUE_DEFINES_SVH
`define POSITIONAL_LIST_QUEUE_DEFINES_SVH

// Concurrent check, muted while reset is held
`define PLQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent check that also runs during reset
`define PLQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/plq_pkg.sv =====
// Shared constants for the positional list queue: depth default, word width,
// action and status codes. No dependencies.
package plq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned WORD_W        = 32;

  // request actions
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd1;
  localparam logic [2:0] ACT_PEEK_FRONT = 3'd2;
  localparam logic [2:0] ACT_PEEK_BACK  = 3'd3;
  localparam logic [2:0] ACT_INSERT_AT  = 3'd4;
  localparam logic [2:0] ACT_REMOVE_AT  = 3'd5;
  localparam logic [2:0] ACT_GET_AT     = 3'd6;

  // result status
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== rtl/plq_store.sv =====
// Entry storage of the positional list queue: one write port, one read
// port with registered read data. Uses plq_pkg for the word width.
module plq_store #(
  parameter int unsigned DEPTH = plq_pkg::DEPTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [$clog2(DEPTH)-1:0]              waddr_i,
  input  logic signed [plq_pkg::WORD_W-1:0]     wdata_i,
  input  logic [$clog2(DEPTH)-1:0]              raddr_i,
  output logic signed [plq_pkg::WORD_W-1:0]     rdata_o
);

  logic signed [plq_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic signed [plq_pkg::WORD_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port (old data on a same-address write)
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/positional_list_queue.sv =====
// Positional list queue top level: request sequencer, index unit, output
// register. Depends on plq_pkg and plq_store.
//
// Usage: a request word (action_i, item_value_i, position_i) is taken on
// in_valid_i && in_ready_o. Each request gives one result word
// (result_value_o, status_o, length_o) on out_valid_o, held until
// out_ready_i. Entries live in a single-port-read, single-port-write memory;
// insert and remove move the tail one entry at a time through a shared
// index step unit (index +/- 1 and a compare).
// Sequencer states after accept, n = length, p = position:
//   push and every error ........ DONE
//   peek and get ................ READ, DONE
//   pop and remove .............. READ, SHRD/SHWR per entry past p, SHRD, DONE
//   insert ...................... SHRD/SHWR per entry from p to n-1, SHRD, DONE
// The block takes one request at a time; in_ready_o is high only while the
// sequencer is idle, and it may take the next request while the previous
// result still waits in the output register. A stalled receiver holds the
// finished result in the sequencer until the output register frees up.
// Reset empties the list and clears out_valid_o; memory contents are not
// cleared and need no clearing pass, as only held entries are ever read.
module positional_list_queue #(
  parameter int unsigned DEPTH = plq_pkg::DEPTH_DEFAULT
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [2:0]                                 action_i,
  input  logic signed [plq_pkg::WORD_W-1:0]          item_value_i,
  input  logic [$clog2(DEPTH+1)-1:0]                 position_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [plq_pkg::WORD_W-1:0]          result_value_o,
  output logic [1:0]                                 status_o,
  output logic [$clog2(DEPTH+1)-1:0]                 length_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SHRD = 3'd2;
  localparam logic [2:0] S_SHWR = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                         state_q, state_d;
  logic [CntW-1:0]                    count_q, count_d;
  logic                               out_valid_q, out_valid_d;

  logic [2:0]                         act_q, act_d;
  logic signed [plq_pkg::WORD_W-1:0]  word_q, word_d;
  logic [CntW-1:0]                    pos_q, pos_d;
  logic [CntW-1:0]                    idx_q, idx_d;
  logic                               up_q, up_d;
  logic signed [plq_pkg::WORD_W-1:0]  res_q, res_d;
  logic [1:0]                         st_q, st_d;

  logic signed [plq_pkg::WORD_W-1:0]  out_value_q, out_value_d;
  logic [1:0]                         out_status_q, out_status_d;
  logic [CntW-1:0]                    out_length_q, out_length_d;

  // memory port
  logic                               mem_we;
  logic [AddrW-1:0]                   mem_waddr, mem_raddr;
  logic signed [plq_pkg::WORD_W-1:0]  mem_wdata, mem_rdata;

  logic                               in_acc, slot_free;
  logic                               is_full, is_empty;
  logic [1:0]                         chk_status;
  logic [CntW-1:0]                    cnt_m1, step;
  logic                               step_go;

  plq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign cnt_m1   = count_q - CntW'(1);

  // shared index unit: one step toward the end of the move, and its limit
  assign step    = up_q ? (idx_q - CntW'(1)) : (idx_q + CntW'(1));
  assign step_go = up_q ? (idx_q > pos_q) : (step < count_q);

  // request check
  always_comb begin
    chk_status = plq_pkg::STATUS_OK;
    case (action_i)
      plq_pkg::ACT_PUSH_BACK: begin
        if (is_full) chk_status = plq_pkg::STATUS_FULL;
      end
      plq_pkg::ACT_POP_FRONT, plq_pkg::ACT_PEEK_FRONT, plq_pkg::ACT_PEEK_BACK: begin
        if (is_empty) chk_status = plq_pkg::STATUS_RANGE;
      end
      plq_pkg::ACT_INSERT_AT: begin
        if (is_full) chk_status = plq_pkg::STATUS_FULL;
        else if (position_i > count_q) chk_status = plq_pkg::STATUS_RANGE;
      end
      plq_pkg::ACT_REMOVE_AT, plq_pkg::ACT_GET_AT: begin
        if (position_i >= count_q) chk_status = plq_pkg::STATUS_RANGE;
      end
      default: chk_status = plq_pkg::STATUS_RANGE;
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    act_d        = act_q;
    word_d       = word_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    up_d         = up_q;
    res_d        = res_q;
    st_d         = st_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_length_d = out_length_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[AddrW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = step[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        case (action_i)
          plq_pkg::ACT_PEEK_BACK: mem_raddr = cnt_m1[AddrW-1:0];
          plq_pkg::ACT_POP_FRONT, plq_pkg::ACT_PEEK_FRONT: mem_raddr = '0;
          default: mem_raddr = position_i[AddrW-1:0];
        endcase
        if (in_acc) begin
          act_d  = action_i;
          word_d = item_value_i;
          pos_d  = (action_i == plq_pkg::ACT_POP_FRONT) ? '0 : position_i;
          up_d   = (action_i == plq_pkg::ACT_INSERT_AT);
          idx_d  = count_q;
          res_d  = '0;
          st_d   = chk_status;
          if (chk_status != plq_pkg::STATUS_OK) begin
            state_d = S_DONE;
          end else begin
            case (action_i)
              plq_pkg::ACT_PUSH_BACK: begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AddrW-1:0];
                mem_wdata = item_value_i;
                count_d   = count_q + CntW'(1);
                state_d   = S_DONE;
              end
              plq_pkg::ACT_INSERT_AT: state_d = S_SHRD;
              default:                state_d = S_READ;
            endcase
          end
        end
      end

      // read data is the result word
      S_READ: begin
        res_d = mem_rdata;
        idx_d = pos_q;
        if (act_q == plq_pkg::ACT_POP_FRONT || act_q == plq_pkg::ACT_REMOVE_AT) begin
          state_d = S_SHRD;
        end else begin
          state_d = S_DONE;
        end
      end

      // fetch the neighbor to move, or finish the move
      S_SHRD: begin
        if (step_go) begin
          mem_raddr = up_q ? step[AddrW-1:0] : step[AddrW-1:0];
          state_d   = S_SHWR;
        end else if (up_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AddrW-1:0];
          mem_wdata = word_q;
          count_d   = count_q + CntW'(1);
          state_d   = S_DONE;
        end else begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end
      end

      // write the fetched neighbor into the current slot
      S_SHWR: begin
        mem_we  = 1'b1;
        idx_d   = step;
        state_d = S_SHRD;
      end

      // hand the result to the output register
      S_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_q;
          out_status_d = st_q;
          out_length_d = count_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    word_q       <= word_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    up_q         <= up_d;
    res_q        <= res_d;
    st_q         <= st_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_length_q <= out_length_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign length_o       = out_length_q;

endmodule

// ===== rtl/plq_checker.sv =====
// Port-level checker for the positional list queue and its bind.
// Depends on plq_pkg and positional_list_queue_defines.svh.
`include "positional_list_queue_defines.svh"

module plq_checker #(
  parameter int unsigned DEPTH = plq_pkg::DEPTH_DEFAULT
) (
  input logic                                       clk_i,
  input logic                                       rst_ni,
  input logic                                       in_valid_i,
  input logic                                       in_ready_o,
  input logic [2:0]                                 action_i,
  input logic signed [plq_pkg::WORD_W-1:0]          item_value_i,
  input logic [$clog2(DEPTH+1)-1:0]                 position_i,
  input logic                                       out_valid_o,
  input logic                                       out_ready_i,
  input logic signed [plq_pkg::WORD_W-1:0]          result_value_o,
  input logic [1:0]                                 status_o,
  input logic [$clog2(DEPTH+1)-1:0]                 length_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // a stalled result word holds
  `PLQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) && $stable(status_o) && $stable(length_o), "result word changed while stalled")

  // failed requests return a zero word
  `PLQ_ASSERT(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != plq_pkg::STATUS_OK |-> result_value_o == '0, "error result carries a nonzero word")

  // length never exceeds the depth
  `PLQ_ASSERT(a_len_bound, clk_i, rst_ni, out_valid_o |-> length_o <= CntW'(DEPTH), "length beyond depth")

  // full status only at full length
  `PLQ_ASSERT(a_full_len, clk_i, rst_ni, out_valid_o && status_o == plq_pkg::STATUS_FULL |-> length_o == CntW'(DEPTH), "full status below full length")

  // no result word during reset
  `PLQ_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind positional_list_queue plq_checker #(.DEPTH(DEPTH)) u_plq_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for positional_list_queue: directed table, then
// biased random requests. Depends on plq_pkg and the positional_list_queue RTL.
// Results are checked against a local list model.
`timescale 1ns / 100ps

module tb_top;
  import plq_pkg::*;

  localparam int unsigned LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int unsigned POS_W        = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W        = $clog2(LIST_DEPTH);
  localparam logic [2:0]  ACT_UNUSED   = 3'd7;
  localparam int          IDLE_PCT     = 36;
  localparam int          RANDOM_WORDS = 1100;
  localparam int          DRAIN_CYCLES = 50;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          STALL_CYCLES = 300;
  localparam int          ROW_COUNT    = 25;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [1:0]               status;
    logic [POS_W-1:0]         length;
  } plq_result_t;

  typedef struct {
    logic [2:0]               act;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         pos;
    int                       reps;
    bit                       typed;
    plq_result_t              exp;
  } dir_row_t;

  // DUT ports
  logic                      clk_i;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic [2:0]                action_i     = ACT_PUSH_BACK;
  logic signed [WORD_W-1:0]  item_value_i = '0;
  logic [POS_W-1:0]          position_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic signed [WORD_W-1:0]  result_value_o;
  logic [1:0]                status_o;
  logic [POS_W-1:0]          length_o;

  // list model and result scoreboard
  logic signed [WORD_W-1:0]  list_words [LIST_DEPTH];
  int unsigned               model_len = 0;
  plq_result_t               pending_results [$];
  int                        error_count = 0;
  int                        cycle_count = 0;

  // burst mode shapes both sides, the pressure request only the receiver
  bit                        burst_mode   = 1'b0;
  bit                        pressure_req = 1'b0;

  dir_row_t                  directed_rows [ROW_COUNT];

  positional_list_queue #(.DEPTH(LIST_DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .item_value_i   (item_value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .length_o       (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("positional_list_queue verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] exp);
    $display("[%0t] mismatch on %s: got %0h expected %0h", $realtime, field, got, exp);
    error_count++;
  endtask

  // Apply one request to the list model and return the word the block should give back
  function automatic plq_result_t list_apply(input logic [2:0] act,
                                             input logic signed [WORD_W-1:0] word,
                                             input int unsigned pos);
    plq_result_t res;
    int unsigned i;
    res = '0;
    res.status = STATUS_OK;
    case (act)
      ACT_PUSH_BACK: begin
        if (model_len >= LIST_DEPTH) res.status = STATUS_FULL;
        else begin
          list_words[IDX_W'(model_len)] = word;
          model_len++;
        end
      end
      ACT_POP_FRONT: begin
        if (model_len == 0) res.status = STATUS_RANGE;
        else begin
          res.value = list_words[0];
          for (i = 0; i + 1 < model_len; i++) begin
            list_words[IDX_W'(i)] = list_words[IDX_W'(i + 1)];
          end
          model_len--;
        end
      end
      ACT_PEEK_FRONT: begin
        if (model_len == 0) res.status = STATUS_RANGE;
        else res.value = list_words[0];
      end
      ACT_PEEK_BACK: begin
        if (model_len == 0) res.status = STATUS_RANGE;
        else res.value = list_words[IDX_W'(model_len - 1)];
      end
      ACT_INSERT_AT: begin
        // full takes priority over a bad position
        if (model_len >= LIST_DEPTH) res.status = STATUS_FULL;
        else if (pos > model_len) res.status = STATUS_RANGE;
        else begin
          for (i = model_len; i > pos; i--) begin
            list_words[IDX_W'(i)] = list_words[IDX_W'(i - 1)];
          end
          list_words[IDX_W'(pos)] = word;
          model_len++;
        end
      end
      ACT_REMOVE_AT: begin
        if (pos >= model_len) res.status = STATUS_RANGE;
        else begin
          res.value = list_words[IDX_W'(pos)];
          for (i = pos; i + 1 < model_len; i++) begin
            list_words[IDX_W'(i)] = list_words[IDX_W'(i + 1)];
          end
          model_len--;
        end
      end
      ACT_GET_AT: begin
        if (pos >= model_len) res.status = STATUS_RANGE;
        else res.value = list_words[IDX_W'(pos)];
      end
      default: res.status = STATUS_RANGE;
    endcase
    res.length = model_len[POS_W-1:0];
    return res;
  endfunction

  // Offer one request word, wait for the handshake, then log its expected result
  task automatic send_word(input logic [2:0] act, input logic signed [WORD_W-1:0] word,
                           input logic [POS_W-1:0] pos, input bit typed,
                           input plq_result_t typed_exp);
    plq_result_t pred;
    if (!burst_mode) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    item_value_i <= word;
    position_i   <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    pred = list_apply(act, word, 32'(pos));
    pending_results.push_back(typed ? typed_exp : pred);
  endtask

  // Receiver: random ready, a burst window, one long hold-off
  int  stall_left = 0;
  bit  stall_done = 1'b0;
  always @(posedge clk_i) begin
    plq_result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", result_value_o, '0);
      end else begin
        exp = pending_results.pop_front();
        if (result_value_o !== exp.value) report_mismatch("value", result_value_o, exp.value);
        if (status_o !== exp.status) begin
          report_mismatch("status", WORD_W'(status_o), WORD_W'(exp.status));
        end
        if (length_o !== exp.length) begin
          report_mismatch("length", WORD_W'(length_o), WORD_W'(exp.length));
        end
      end
    end
    if (pressure_req && !stall_done) begin
      stall_left = STALL_CYCLES;
      stall_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (burst_mode) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stimulus
  initial begin
    logic [2:0]               act;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         pos;
    int                       r;
    int                       fill_goal;
    int unsigned              len;
    bit                       grow;

    // directed table: typed results only where obvious
    directed_rows = '{
      '{ACT_POP_FRONT,  32'sd0,         5'd0,  1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}},
      '{ACT_PEEK_FRONT, 32'sd0,         5'd0,  1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}},
      '{ACT_PEEK_BACK,  32'sd0,         5'd0,  1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}},
      '{ACT_REMOVE_AT,  32'sd0,         5'd0,  1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}},
      '{ACT_GET_AT,     32'sd0,         5'd0,  1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}},
      '{ACT_INSERT_AT,  32'sd5,         5'd1,  1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}},
      '{ACT_UNUSED,     32'sd7,         5'd31, 1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}},
      '{ACT_PUSH_BACK,  32'h7fffffff,   5'd0,  1,  1'b1, '{32'sd0, STATUS_OK,    5'd1}},
      '{ACT_INSERT_AT,  32'h80000000,   5'd0,  1,  1'b1, '{32'sd0, STATUS_OK,    5'd2}},
      '{ACT_INSERT_AT,  -32'sd1,        5'd2,  1,  1'b0, '0},
      '{ACT_INSERT_AT,  32'sd9,         5'd31, 1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd3}},
      '{ACT_GET_AT,     32'sd0,         5'd1,  1,  1'b0, '0},
      '{ACT_PEEK_FRONT, 32'sd0,         5'd0,  1,  1'b0, '0},
      '{ACT_PEEK_BACK,  32'sd0,         5'd0,  1,  1'b0, '0},
      '{ACT_REMOVE_AT,  32'sd0,         5'd1,  1,  1'b0, '0},
      '{ACT_GET_AT,     32'sd0,         5'd16, 1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd2}},
      '{ACT_PUSH_BACK,  32'sd0,         5'd0,  14, 1'b0, '0},
      '{ACT_PUSH_BACK,  32'sd3,         5'd0,  1,  1'b1, '{32'sd0, STATUS_FULL,  5'd16}},
      '{ACT_INSERT_AT,  32'sd4,         5'd0,  1,  1'b1, '{32'sd0, STATUS_FULL,  5'd16}},
      '{ACT_INSERT_AT,  32'sd4,         5'd31, 1,  1'b1, '{32'sd0, STATUS_FULL,  5'd16}},
      '{ACT_GET_AT,     32'sd0,         5'd15, 1,  1'b0, '0},
      '{ACT_REMOVE_AT,  32'sd0,         5'd15, 1,  1'b0, '0},
      '{ACT_REMOVE_AT,  32'sd0,         5'd0,  1,  1'b0, '0},
      '{ACT_POP_FRONT,  32'sd0,         5'd0,  14, 1'b0, '0},
      '{ACT_PEEK_BACK,  32'sd0,         5'd0,  1,  1'b1, '{32'sd0, STATUS_RANGE, 5'd0}}
    };

    // reset, once
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      for (int j = 0; j < directed_rows[k].reps; j++) begin
        word = (directed_rows[k].reps > 1) ? $urandom : directed_rows[k].word;
        send_word(directed_rows[k].act, word, directed_rows[k].pos,
                  directed_rows[k].typed, directed_rows[k].exp);
      end
    end

    // random part: the length wanders toward a goal that is redrawn now and then
    fill_goal = LIST_DEPTH;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      burst_mode = (n >= 200 && n < 380);
      if (n == 700) pressure_req = 1'b1;
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0:       fill_goal = 0;
          1:       fill_goal = LIST_DEPTH;
          default: fill_goal = $urandom_range(LIST_DEPTH);
        endcase
      end
      len = model_len;
      case ($urandom_range(7))
        0:       word = 32'h7fffffff;
        1:       word = 32'h80000000;
        2:       word = -32'sd1;
        default: word = $urandom;
      endcase
      pos = '0;
      r = $urandom_range(99);
      if (r < 5) begin
        // noise: any code, any position
        act = 3'($urandom_range(7));
        pos = POS_W'($urandom_range(31));
      end else if (r < 27) begin
        case ($urandom_range(2))
          0:       act = ACT_PEEK_FRONT;
          1:       act = ACT_PEEK_BACK;
          default: act = ACT_GET_AT;
        endcase
        pos = (len > 0) ? POS_W'($urandom_range(len - 1)) : '0;
      end else begin
        grow = (len < fill_goal) || (len == fill_goal && $urandom_range(1));
        if (grow) begin
          act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_INSERT_AT;
          pos = POS_W'($urandom_range(len));
        end else begin
          act = $urandom_range(1) ? ACT_POP_FRONT : ACT_REMOVE_AT;
          pos = (len > 0) ? POS_W'($urandom_range(len - 1)) : '0;
        end
      end
      // occasional bad position
      if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(31));
      send_word(act, word, pos, 1'b0, '0);
    end
    burst_mode = 1'b0;
    in_valid_i <= 1'b0;

    // drain and settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("positional_list_queue verification clean");
    end else begin
      $display("positional_list_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== positional_list_queue.f =====
+incdir+rtl
rtl/plq_pkg.sv
rtl/plq_store.sv
rtl/positional_list_queue.sv
rtl/plq_checker.sv
tb/tb_top.sv
